// ===== rtl/fdem_pkg.sv =====
// Shared types and constants of the feedback delay echo mixer.
// Holds the item structs, the register index codes and the reset values.
// No dependencies.
package fdem_pkg;

  localparam int unsigned FRAMES_DEFAULT   = 4096;
  localparam int unsigned CHANNELS_DEFAULT = 8;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 3'd0,
    CFG_RING_FRAMES   = 3'd1,
    CFG_DELAY_FRAMES  = 3'd2,
    CFG_WET_GAIN      = 3'd3,
    CFG_DRY_GAIN      = 3'd4,
    CFG_ECHO_FEEDBACK = 3'd5
  } cfg_reg_e;

  localparam int unsigned RST_CHANNEL_COUNT = 2;
  localparam int unsigned RST_RING_FRAMES   = 4096;
  localparam int unsigned RST_DELAY_FRAMES  = 1024;
  localparam int unsigned RST_WET_GAIN      = 4096;
  localparam int unsigned RST_DRY_GAIN      = 4096;
  localparam int unsigned RST_ECHO_FEEDBACK = 0;

  typedef struct packed {
    logic signed [23:0] dry_sample;
    logic               end_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mixed_sample;
    logic [2:0]         chan_idx;
    logic               block_done;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] wet;
    logic signed [15:0] dry;
    logic signed [15:0] feedback;
  } gains_t;

endpackage

// ===== rtl/fdem_rem_unit.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Used by the front end to wrap ring positions; depends on nothing else.
module fdem_rem_unit #(
  parameter int unsigned DW = 12,
  parameter int unsigned RW = 13,
  localparam int unsigned CNTW = $clog2(DW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [RW-1:0] divisor_i,
  output logic          done_o,
  output logic [RW-1:0] rem_o
);

  logic            run_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   num_q;
  logic [RW-1:0]   div_q;
  logic [RW-1:0]   part_q;
  logic [RW:0]     shifted;
  logic [RW:0]     diff;
  logic            ge;

  always_comb begin
    shifted = {part_q, num_q[DW-1]};
    ge      = shifted >= {1'b0, div_q};
    diff    = shifted - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNTW'(DW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      div_q  <= divisor_i;
      part_q <= '0;
    end else if (run_q) begin
      num_q  <= num_q << 1;
      // The partial remainder stays below the divisor, so it fits RW bits.
      part_q <= ge ? RW'(diff) : RW'(shifted);
    end
  end

  assign done_o = done_q;
  assign rem_o  = part_q;

endmodule

// ===== rtl/fdem_front.sv =====
// Front end: accepts sample beats, tracks channel and ring positions, and
// holds the configuration registers. Depends on fdem_pkg and fdem_rem_unit.
module fdem_front #(
  parameter int unsigned MAX_FRAMES   = fdem_pkg::FRAMES_DEFAULT,
  parameter int unsigned MAX_CHANNELS = fdem_pkg::CHANNELS_DEFAULT,
  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned AW = $clog2(MAX_FRAMES * MAX_CHANNELS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fdem_pkg::in_item_t                  in_data_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fdem_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fdem_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                init_done_i,
  input  logic                                queue_full_i,
  output logic                                push_o,
  output logic signed [23:0]                  op_x_o,
  output logic                                op_eob_o,
  output logic [CW-1:0]                       op_ch_o,
  output logic [AW-1:0]                       op_ra_o,
  output logic [AW-1:0]                       op_wa_o,
  output fdem_pkg::gains_t                    gains_o
);

  localparam int unsigned FIW = $clog2(MAX_FRAMES);
  localparam int unsigned RW  = FIW + 1;
  localparam int unsigned DW  = (FIW > 12) ? FIW : 12;
  localparam int unsigned ECW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned RstRing =
    (MAX_FRAMES < fdem_pkg::RST_RING_FRAMES) ? MAX_FRAMES : fdem_pkg::RST_RING_FRAMES;
  localparam int unsigned RstWi = fdem_pkg::RST_DELAY_FRAMES % RstRing;

  typedef enum logic [1:0] {
    CF_IDLE,
    CF_RING_RD,
    CF_RING_WR,
    CF_DELAY
  } cfg_state_e;

  cfg_state_e       state_q;
  logic             start_q;
  logic [3:0]       cnt_q;
  logic [12:0]      ring_q;
  logic [11:0]      delay_q;
  fdem_pkg::gains_t gains_q;
  logic [FIW-1:0]   ri_q;
  logic [FIW-1:0]   wi_q;
  logic [CW-1:0]    ch_q;

  logic [ECW-1:0]   eff_ch;
  logic [RW-1:0]    eff_ring;
  logic             last_ch;
  logic [RW-1:0]    ri_inc;
  logic [RW-1:0]    wi_inc;
  logic [FIW-1:0]   ri_next;
  logic [FIW-1:0]   wi_next;
  logic [DW-1:0]    rem_dividend;
  logic             rem_done;
  logic [RW-1:0]    rem;
  logic [RW-1:0]    place_sum;
  logic [FIW-1:0]   place_wi;

  always_comb begin
    if (cnt_q == '0) begin
      eff_ch = ECW'(1);
    end else if (32'(cnt_q) > MAX_CHANNELS) begin
      eff_ch = ECW'(MAX_CHANNELS);
    end else begin
      eff_ch = ECW'(cnt_q);
    end
    if (ring_q == '0) begin
      eff_ring = RW'(1);
    end else if (32'(ring_q) > MAX_FRAMES) begin
      eff_ring = RW'(MAX_FRAMES);
    end else begin
      eff_ring = RW'(ring_q);
    end
    // A counter left beyond a shrunk channel count also ends the frame.
    last_ch   = (32'(ch_q) + 32'd1) >= 32'(eff_ch);
    ri_inc    = RW'(ri_q) + RW'(1);
    wi_inc    = RW'(wi_q) + RW'(1);
    ri_next   = (ri_inc >= eff_ring) ? '0 : FIW'(ri_inc);
    wi_next   = (wi_inc >= eff_ring) ? '0 : FIW'(wi_inc);
    place_sum = RW'(ri_q) + rem;
    place_wi  = (place_sum >= eff_ring) ? FIW'(place_sum - eff_ring) : FIW'(place_sum);
    unique case (state_q)
      CF_RING_RD: rem_dividend = DW'(ri_q);
      CF_RING_WR: rem_dividend = DW'(wi_q);
      CF_DELAY:   rem_dividend = DW'(delay_q);
      CF_IDLE:    rem_dividend = '0;
    endcase
  end

  fdem_rem_unit #(
    .DW(DW),
    .RW(RW)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .dividend_i(rem_dividend),
    .divisor_i (eff_ring),
    .done_o    (rem_done),
    .rem_o     (rem)
  );

  assign cfg_ready_o = (state_q == CF_IDLE);
  assign in_ready_o  = (state_q == CF_IDLE) && init_done_i && !queue_full_i;
  assign push_o      = in_valid_i && in_ready_o;

  assign op_x_o   = in_data_i.dry_sample;
  assign op_eob_o = in_data_i.end_of_block;
  assign op_ch_o  = ch_q;
  assign op_ra_o  = AW'(ri_q) * AW'(MAX_CHANNELS) + AW'(ch_q);
  assign op_wa_o  = AW'(wi_q) * AW'(MAX_CHANNELS) + AW'(ch_q);
  assign gains_o  = gains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= CF_IDLE;
      start_q          <= 1'b0;
      cnt_q            <= 4'(fdem_pkg::RST_CHANNEL_COUNT);
      ring_q           <= 13'(fdem_pkg::RST_RING_FRAMES);
      delay_q          <= 12'(fdem_pkg::RST_DELAY_FRAMES);
      gains_q.wet      <= 16'(fdem_pkg::RST_WET_GAIN);
      gains_q.dry      <= 16'(fdem_pkg::RST_DRY_GAIN);
      gains_q.feedback <= 16'(fdem_pkg::RST_ECHO_FEEDBACK);
      ri_q             <= '0;
      wi_q             <= FIW'(RstWi);
      ch_q             <= '0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        CF_IDLE: begin
          if (push_o) begin
            if (last_ch) begin
              ch_q <= '0;
              ri_q <= ri_next;
              wi_q <= wi_next;
            end else begin
              ch_q <= ch_q + 1'b1;
            end
          end
          if (cfg_valid_i) begin
            unique case (cfg_index_i)
              fdem_pkg::CFG_CHANNEL_COUNT: cnt_q <= cfg_data_i[3:0];
              fdem_pkg::CFG_RING_FRAMES: begin
                ring_q  <= cfg_data_i[12:0];
                state_q <= CF_RING_RD;
                start_q <= 1'b1;
              end
              fdem_pkg::CFG_DELAY_FRAMES: begin
                delay_q <= cfg_data_i[11:0];
                state_q <= CF_DELAY;
                start_q <= 1'b1;
              end
              fdem_pkg::CFG_WET_GAIN:      gains_q.wet      <= cfg_data_i;
              fdem_pkg::CFG_DRY_GAIN:      gains_q.dry      <= cfg_data_i;
              fdem_pkg::CFG_ECHO_FEEDBACK: gains_q.feedback <= cfg_data_i;
              default: ;
            endcase
          end
        end
        CF_RING_RD: begin
          if (rem_done) begin
            ri_q    <= FIW'(rem);
            state_q <= CF_RING_WR;
            start_q <= 1'b1;
          end
        end
        CF_RING_WR: begin
          if (rem_done) begin
            wi_q    <= FIW'(rem);
            state_q <= CF_IDLE;
          end
        end
        CF_DELAY: begin
          // The read position is already reduced, so one wrap suffices.
          if (rem_done) begin
            wi_q    <= place_wi;
            state_q <= CF_IDLE;
          end
        end
      endcase
    end
  end

  a_no_beat_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != CF_IDLE |-> !in_ready_o)
    else $error("sample beat possible during a position update");

  a_positions_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CF_IDLE && $past(state_q) != CF_IDLE)
      |-> (RW'(ri_q) < eff_ring && RW'(wi_q) < eff_ring))
    else $error("ring positions outside the ring after a register write");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && last_ch && !cfg_valid_i) |=> ch_q == '0)
    else $error("channel counter did not return to zero at the end of a frame");

endmodule

// ===== rtl/fdem_fifo.sv =====
// Short queue between the front end and the back end.
// Depends on fdem_pkg for its depth.
module fdem_fifo #(
  parameter int unsigned WIDTH = 8,
  localparam int unsigned Depth = fdem_pkg::QUEUE_DEPTH,
  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CNTW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] slot_q [Depth];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [CNTW-1:0]  count_q;

  assign full_o  = (count_q == CNTW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CNTW'(push_i) - CNTW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/fdem_back.sv =====
// Back end: delay memory with its clearing pass, the multiply stage, the
// mix and write-back stage and the output register. Depends on fdem_pkg.
module fdem_back #(
  parameter int unsigned MAX_FRAMES   = fdem_pkg::FRAMES_DEFAULT,
  parameter int unsigned MAX_CHANNELS = fdem_pkg::CHANNELS_DEFAULT,
  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned AW = $clog2(MAX_FRAMES * MAX_CHANNELS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  output logic                op_ready_o,
  input  logic signed [23:0]  op_x_i,
  input  logic                op_eob_i,
  input  logic [CW-1:0]       op_ch_i,
  input  logic [AW-1:0]       op_ra_i,
  input  logic [AW-1:0]       op_wa_i,
  input  fdem_pkg::gains_t    gains_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fdem_pkg::out_item_t out_data_o,
  output logic                init_done_o
);

  localparam int unsigned Depth = MAX_FRAMES * MAX_CHANNELS;

  logic signed [15:0] delay_mem_q [Depth];
  logic [AW-1:0]      clr_addr_q;
  logic               init_done_q;
  logic signed [15:0] rd_data_q;

  logic               s1_valid_q;
  logic signed [23:0] s1_x_q;
  logic               s1_eob_q;
  logic [CW-1:0]      s1_ch_q;
  logic [AW-1:0]      s1_wa_q;

  logic               s2_valid_q;
  logic signed [31:0] s2_wet_q;
  logic signed [39:0] s2_dry_q;
  logic signed [31:0] s2_fb_q;
  logic signed [23:0] s2_x_q;
  logic               s2_eob_q;
  logic [CW-1:0]      s2_ch_q;
  logic [AW-1:0]      s2_wa_q;

  logic                out_valid_q;
  fdem_pkg::out_item_t out_data_q;

  logic               adv;
  logic               hazard;
  logic               issue;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [15:0] mem_wdata;
  logic signed [31:0] wet_prod;
  logic signed [39:0] dry_prod;
  logic signed [31:0] fb_prod;
  logic signed [41:0] mix_sum;
  logic signed [41:0] mix_shr;
  logic signed [32:0] fb_sum;
  logic signed [32:0] fb_adj;
  logic signed [32:0] fb_shr;
  logic signed [15:0] fb_sat;

  // The whole pipeline moves together whenever the output register frees up.
  assign adv = !out_valid_q || out_ready_i;

  // A read must not overtake a write still in flight to the same entry.
  assign hazard     = (s1_valid_q && s1_wa_q == op_ra_i) || (s2_valid_q && s2_wa_q == op_ra_i);
  assign op_ready_o = adv && init_done_q && !hazard;
  assign issue      = op_valid_i && op_ready_o;

  always_comb begin
    wet_prod = 32'(rd_data_q) * 32'(gains_i.wet);
    dry_prod = 40'(s1_x_q) * 40'(gains_i.dry);
    fb_prod  = 32'(rd_data_q) * 32'(gains_i.feedback);

    // Rounded mix; its magnitude stays well inside 32 bits.
    mix_sum = (42'(s2_wet_q) <<< 5) + 42'(s2_dry_q) + 42'sd2048;
    mix_shr = mix_sum >>> 12;

    // Write-back truncates toward zero, then saturates to 16 bits.
    fb_sum = 33'(s2_fb_q) + (33'(s2_x_q) <<< 7);
    fb_adj = fb_sum[32] ? fb_sum + 33'sd4095 : fb_sum;
    fb_shr = fb_adj >>> 12;
    if (fb_shr > 33'sd32767) begin
      fb_sat = 16'sh7fff;
    end else if (fb_shr < -33'sd32768) begin
      fb_sat = 16'sh8000;
    end else begin
      fb_sat = fb_shr[15:0];
    end

    mem_we    = !init_done_q || (adv && s2_valid_q);
    mem_waddr = init_done_q ? s2_wa_q : clr_addr_q;
    mem_wdata = init_done_q ? fb_sat : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      init_done_q <= 1'b0;
    end else if (!init_done_q) begin
      if (clr_addr_q == AW'(Depth - 1)) begin
        init_done_q <= 1'b1;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      delay_mem_q[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data_q <= delay_mem_q[op_ra_i];
      s1_x_q    <= op_x_i;
      s1_eob_q  <= op_eob_i;
      s1_ch_q   <= op_ch_i;
      s1_wa_q   <= op_wa_i;
    end
    if (adv && s1_valid_q) begin
      s2_wet_q <= wet_prod;
      s2_dry_q <= dry_prod;
      s2_fb_q  <= fb_prod;
      s2_x_q   <= s1_x_q;
      s2_eob_q <= s1_eob_q;
      s2_ch_q  <= s1_ch_q;
      s2_wa_q  <= s1_wa_q;
    end
    if (adv && s2_valid_q) begin
      out_data_q.mixed_sample <= mix_shr[31:0];
      out_data_q.chan_idx     <= 3'(s2_ch_q);
      out_data_q.block_done   <= s2_eob_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign init_done_o = init_done_q;

  a_idle_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done_q |-> (!s1_valid_q && !s2_valid_q && !out_valid_q))
    else $error("item in the pipeline during the clearing pass");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_done_q |=> init_done_q)
    else $error("clearing pass restarted without reset");

  a_stall_holds_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !adv) |=> (s2_valid_q && $stable(s2_wa_q)))
    else $error("write-back stage lost or changed its entry during a stall");

endmodule

// ===== rtl/feedback_delay_echo_mixer_core.sv =====
// Top level of the feedback delay echo mixer.
// Depends on fdem_pkg, fdem_front, fdem_fifo and fdem_back.
//
// Channels: in_valid_i/in_ready_o carry one interleaved dry sample per beat,
// out_valid_o/out_ready_i return one mixed sample per beat in the same order,
// and cfg_valid_i/cfg_ready_o write one register per beat (index 0 channel
// count, 1 ring frames, 2 delay frames, 3 wet gain, 4 dry gain, 5 feedback).
// Path: queue, then the read, multiply and output registers.
// Throughput: one sample per cycle while the output is taken. The delay
// memory has one read and one write port; a sample whose read entry still
// has a write pending in the two stages behind the read waits for it. This
// only arises with one channel and a delay of one or two frames, or with two
// channels and a delay of one frame, both counted modulo the ring length.
// A ring or delay write runs a bit-serial remainder for each position, with
// cfg_ready_o and in_ready_o low meanwhile.
// Reset: the delay memory is cleared one entry per cycle, all MAX_FRAMES times
// MAX_CHANNELS entries (32768 by default); in_ready_o stays low until done,
// while register writes are taken.
// Stall: a held output keeps the result and holds the pipeline; a two-entry
// queue keeps taking samples until it is full.
module feedback_delay_echo_mixer_core #(
  parameter int unsigned MAX_FRAMES   = fdem_pkg::FRAMES_DEFAULT,
  parameter int unsigned MAX_CHANNELS = fdem_pkg::CHANNELS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fdem_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fdem_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fdem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fdem_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned AW = $clog2(MAX_FRAMES * MAX_CHANNELS);
  localparam int unsigned QW = 24 + 1 + CW + 2 * AW;

  logic               init_done;
  logic               q_full;
  logic               push;
  logic signed [23:0] f_x;
  logic               f_eob;
  logic [CW-1:0]      f_ch;
  logic [AW-1:0]      f_ra;
  logic [AW-1:0]      f_wa;
  fdem_pkg::gains_t   gains;
  logic [QW-1:0]      q_wdata;
  logic [QW-1:0]      q_rdata;
  logic               q_valid;
  logic               q_pop;
  logic               q_pop_ready;
  logic signed [23:0] b_x;
  logic               b_eob;
  logic [CW-1:0]      b_ch;
  logic [AW-1:0]      b_ra;
  logic [AW-1:0]      b_wa;

  fdem_front #(
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .init_done_i (init_done),
    .queue_full_i(q_full),
    .push_o      (push),
    .op_x_o      (f_x),
    .op_eob_o    (f_eob),
    .op_ch_o     (f_ch),
    .op_ra_o     (f_ra),
    .op_wa_o     (f_wa),
    .gains_o     (gains)
  );

  assign q_wdata = {f_x, f_eob, f_ch, f_ra, f_wa};

  fdem_fifo #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  assign {b_x, b_eob, b_ch, b_ra, b_wa} = q_rdata;

  fdem_back #(
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_ready_o (q_pop_ready),
    .op_x_i     (b_x),
    .op_eob_i   (b_eob),
    .op_ch_i    (b_ch),
    .op_ra_i    (b_ra),
    .op_wa_i    (b_wa),
    .gains_i    (gains),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .init_done_o(init_done)
  );

  assign q_pop = q_valid && q_pop_ready;

endmodule

// ===== dv/feedback_delay_echo_mixer_core_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the feedback delay echo mixer: watches the sample, mix and register channels,
// predicts every mixed sample from its own echo store, and counts mismatches.
// Depends on fdem_pkg.
module feedback_delay_echo_mixer_core_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  fdem_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  fdem_pkg::out_item_t             out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [fdem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fdem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  localparam int unsigned CH          = fdem_pkg::CHANNELS_DEFAULT;
  localparam int unsigned STORE_DEPTH = fdem_pkg::FRAMES_DEFAULT * fdem_pkg::CHANNELS_DEFAULT;
  localparam longint      MIX_MAX     = 64'sd2147483647;
  localparam longint      MIX_MIN     = -64'sd2147483648;
  localparam longint      ECHO_MAX    = 32767;
  localparam longint      ECHO_MIN    = -32768;

  logic signed [15:0] echo_mem [STORE_DEPTH];
  int unsigned        rd_frame;
  int unsigned        wr_frame;
  int unsigned        chan_pos;

  logic [3:0]         chan_cfg;
  logic [12:0]        ring_cfg;
  logic [11:0]        delay_cfg;
  int                 wet_gain;
  int                 dry_gain;
  int                 fb_gain;

  fdem_pkg::out_item_t mix_q[$];
  int unsigned         mismatches = 0;

  function automatic int unsigned chans();
    if (chan_cfg == 0) return 1;
    if (chan_cfg > CH) return CH;
    return chan_cfg;
  endfunction

  function automatic int unsigned ring_len();
    if (ring_cfg == 0) return 1;
    if (ring_cfg > fdem_pkg::FRAMES_DEFAULT) return fdem_pkg::FRAMES_DEFAULT;
    return ring_cfg;
  endfunction

  function automatic void load_reset_state();
    foreach (echo_mem[i]) echo_mem[i] = '0;
    chan_cfg  = 4'(fdem_pkg::RST_CHANNEL_COUNT);
    ring_cfg  = 13'(fdem_pkg::RST_RING_FRAMES);
    delay_cfg = 12'(fdem_pkg::RST_DELAY_FRAMES);
    wet_gain  = fdem_pkg::RST_WET_GAIN;
    dry_gain  = fdem_pkg::RST_DRY_GAIN;
    fb_gain   = fdem_pkg::RST_ECHO_FEEDBACK;
    rd_frame  = 0;
    chan_pos  = 0;
    wr_frame  = delay_cfg % ring_len();
  endfunction

  function automatic void apply_reg(logic [fdem_pkg::CFG_IDX_W-1:0] idx,
                                    logic [fdem_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      fdem_pkg::CFG_CHANNEL_COUNT: chan_cfg = value[3:0];
      fdem_pkg::CFG_RING_FRAMES: begin
        ring_cfg = value[12:0];
        rd_frame = rd_frame % ring_len();
        wr_frame = wr_frame % ring_len();
      end
      fdem_pkg::CFG_DELAY_FRAMES: begin
        delay_cfg = value[11:0];
        wr_frame  = (rd_frame % ring_len() + delay_cfg % ring_len()) % ring_len();
      end
      fdem_pkg::CFG_WET_GAIN:      wet_gain = $signed(value);
      fdem_pkg::CFG_DRY_GAIN:      dry_gain = $signed(value);
      fdem_pkg::CFG_ECHO_FEEDBACK: fb_gain  = $signed(value);
      default: ;
    endcase
  endfunction

  // Mixes one dry sample with the echo held for its channel, then writes the new echo back.
  function automatic fdem_pkg::out_item_t echo_step(fdem_pkg::in_item_t beat);
    fdem_pkg::out_item_t res;
    longint              dry;
    longint              held;
    longint              mix;
    longint              back;
    dry  = longint'($signed(beat.dry_sample));
    held = longint'(echo_mem[rd_frame * CH + chan_pos]);

    // Arithmetic shift floors, so adding half an LSB rounds ties upward.
    mix = (32 * held * wet_gain + dry * dry_gain + 2048) >>> 12;
    if (mix > MIX_MAX) mix = MIX_MAX;
    if (mix < MIX_MIN) mix = MIX_MIN;

    // The echo write-back truncates toward zero instead.
    back = (held * fb_gain + 128 * dry) / 4096;
    if (back > ECHO_MAX) back = ECHO_MAX;
    if (back < ECHO_MIN) back = ECHO_MIN;
    echo_mem[wr_frame * CH + chan_pos] = back[15:0];

    res.mixed_sample = mix[31:0];
    res.chan_idx     = 3'(chan_pos);
    res.block_done   = beat.end_of_block;

    if (chan_pos + 1 >= chans()) begin
      chan_pos = 0;
      rd_frame = (rd_frame + 1 >= ring_len()) ? 0 : rd_frame + 1;
      wr_frame = (wr_frame + 1 >= ring_len()) ? 0 : wr_frame + 1;
    end else begin
      chan_pos++;
    end
    return res;
  endfunction

  task automatic flag_field(input string field, input longint want, input longint got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin : monitor
    fdem_pkg::out_item_t want;
    if (!rst_ni) begin
      load_reset_state();
      mix_q.delete();
    end else begin
      // Results leave before new samples are predicted, so a stray beat cannot match a fresh one.
      if (out_valid_i && out_ready_i) begin
        if (mix_q.size() == 0) begin
          mismatches++;
          $display("%0t: output beat with nothing pending, expected none, actual %0d ch %0d done %0b",
                   $time, out_data_i.mixed_sample, out_data_i.chan_idx,
                   out_data_i.block_done);
        end else begin
          want = mix_q.pop_front();
          if (out_data_i.mixed_sample !== want.mixed_sample)
            flag_field("mixed_sample", want.mixed_sample, out_data_i.mixed_sample);
          if (out_data_i.chan_idx !== want.chan_idx)
            flag_field("chan_idx", want.chan_idx, out_data_i.chan_idx);
          if (out_data_i.block_done !== want.block_done)
            flag_field("block_done", want.block_done, out_data_i.block_done);
        end
      end
      if (cfg_valid_i && cfg_ready_i) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) mix_q.push_back(echo_step(in_data_i));
    end
    fail_count_o <= mismatches;
    pending_o    <= mix_q.size();
  end

endmodule

// ===== dv/feedback_delay_echo_mixer_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top of the feedback delay echo mixer: clock, reset, register setup, sample stimulus
// with random gaps and stalls, and the verdict. Depends on fdem_pkg,
// feedback_delay_echo_mixer_core and feedback_delay_echo_mixer_core_checker.
module feedback_delay_echo_mixer_core_tb;

  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned QUIET_ITEMS  = 120;
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam int unsigned TAIL_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam logic [fdem_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [fdem_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  fdem_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  fdem_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [fdem_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fdem_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned                     fail_count;
  int unsigned                     pending;

  bit          idle_on  = 1'b0;  // random gaps and stalls allowed in this phase
  bit          quiet    = 1'b0;  // closing stretch runs at full rate on both sides
  bit          hold_req = 1'b0;
  int unsigned ring_now = fdem_pkg::RST_RING_FRAMES;

  feedback_delay_echo_mixer_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  feedback_delay_echo_mixer_core_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("feedback_delay_echo_mixer_core verification failed");
    $finish;
  end

  // Mix receiver: short random stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned gap;
    forever begin
      @(posedge clk);
      if (hold_req && !quiet) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && !quiet && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(input logic [fdem_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [fdem_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_sample(input fdem_pkg::in_item_t beat);
    int unsigned gap;
    if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // The pending count is a registered copy of the checker's queue size, hence the first wait.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic fdem_pkg::in_item_t make_sample(input int value, input bit last);
    fdem_pkg::in_item_t s;
    s.dry_sample   = value[23:0];
    s.end_of_block = last;
    return s;
  endfunction

  function automatic fdem_pkg::in_item_t random_sample();
    fdem_pkg::in_item_t s;
    case ($urandom_range(0, 7))
      0:       s.dry_sample = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      1:       s.dry_sample = 24'($urandom_range(0, 1023)) - 24'd512;
      default: s.dry_sample = 24'($urandom);
    endcase
    s.end_of_block = ($urandom_range(0, 7) == 0);
    return s;
  endfunction

  function automatic logic [fdem_pkg::CFG_DATA_W-1:0] random_gain();
    logic [fdem_pkg::CFG_DATA_W-1:0] g;
    case ($urandom_range(0, 5))
      0:       g = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1:       g = 16'($urandom);
      default: g = 16'($urandom_range(0, 8192) - 4096);
    endcase
    return g;
  endfunction

  // Small rings and short delays keep echoes coming back within a phase.
  task automatic random_setup(input bit every_reg);
    logic [fdem_pkg::CFG_DATA_W-1:0] v;
    int unsigned                     span;
    if (every_reg || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       v = 16'd0;
        1:       v = 16'($urandom_range(9, 15));
        default: v = 16'($urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 7) == 0) v[15:4] = 12'($urandom);
      write_reg(fdem_pkg::CFG_CHANNEL_COUNT, v);
    end
    if (every_reg || $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 11))
        0:       v = 16'd0;
        1:       v = 16'($urandom_range(4097, 8191));
        2:       v = 16'd4096;
        3:       v = 16'($urandom_range(17, 300));
        default: v = 16'($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 7) == 0) v[15:13] = 3'($urandom);
      ring_now = (v[12:0] == 0) ? 1 : ((v[12:0] > 4096) ? 4096 : v[12:0]);
      write_reg(fdem_pkg::CFG_RING_FRAMES, v);
    end
    if (every_reg || $urandom_range(0, 2) == 0) begin
      span = (ring_now < 20) ? ring_now + 2 : 22;
      v = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
      write_reg(fdem_pkg::CFG_DELAY_FRAMES, v);
    end
    if (every_reg || $urandom_range(0, 1) == 0)
      write_reg(fdem_pkg::CFG_WET_GAIN, random_gain());
    if (every_reg || $urandom_range(0, 1) == 0)
      write_reg(fdem_pkg::CFG_DRY_GAIN, random_gain());
    if (every_reg || $urandom_range(0, 1) == 0)
      write_reg(fdem_pkg::CFG_ECHO_FEEDBACK, random_gain());
    if ($urandom_range(0, 5) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    // Reset settings: the ring is long, so samples pass straight through.
    send_sample(make_sample(8388607, 1'b1));
    send_sample(make_sample(-8388608, 1'b0));
    send_sample(make_sample(0, 1'b0));
    send_sample(make_sample(-1, 1'b1));
    drain();

    // One channel with a one-frame delay in a two-frame ring reads each echo right after
    // its write; gains at full scale push the write-back into saturation.
    write_reg(fdem_pkg::CFG_CHANNEL_COUNT, 16'd1);
    write_reg(fdem_pkg::CFG_RING_FRAMES, 16'd2);
    write_reg(fdem_pkg::CFG_DELAY_FRAMES, 16'd1);
    write_reg(fdem_pkg::CFG_WET_GAIN, 16'h7fff);
    write_reg(fdem_pkg::CFG_DRY_GAIN, 16'h7fff);
    write_reg(fdem_pkg::CFG_ECHO_FEEDBACK, 16'h7fff);
    cfg_valid <= 1'b0;
    send_sample(make_sample(8388607, 1'b0));
    send_sample(make_sample(8388607, 1'b0));
    send_sample(make_sample(-8388608, 1'b0));
    send_sample(make_sample(-8388608, 1'b1));
    send_sample(make_sample(8388607, 1'b0));
    send_sample(make_sample(12345, 1'b1));
    drain();

    // Zero channel count and zero ring length both act as one; with zero delay the old
    // echo is read before it is overwritten. Gains sit at their negative end.
    write_reg(fdem_pkg::CFG_CHANNEL_COUNT, 16'd0);
    write_reg(fdem_pkg::CFG_RING_FRAMES, 16'd0);
    write_reg(fdem_pkg::CFG_DELAY_FRAMES, 16'd0);
    write_reg(fdem_pkg::CFG_WET_GAIN, 16'h8000);
    write_reg(fdem_pkg::CFG_DRY_GAIN, 16'h8000);
    write_reg(fdem_pkg::CFG_ECHO_FEEDBACK, 16'h8000);
    cfg_valid <= 1'b0;
    send_sample(make_sample(-8388608, 1'b0));
    send_sample(make_sample(8388607, 1'b1));
    send_sample(make_sample(-8388608, 1'b0));
    send_sample(make_sample(4660, 1'b0));
    drain();

    // Oversized channel count and ring length saturate; writes beyond the register
    // list change nothing.
    write_reg(fdem_pkg::CFG_CHANNEL_COUNT, 16'd15);
    write_reg(fdem_pkg::CFG_RING_FRAMES, 16'd8191);
    write_reg(fdem_pkg::CFG_DELAY_FRAMES, 16'd4095);
    write_reg(CFG_SPARE_LO, 16'hffff);
    write_reg(CFG_SPARE_HI, 16'h5a5a);
    cfg_valid <= 1'b0;
    send_sample(make_sample(1000000, 1'b0));
    send_sample(make_sample(-1000000, 1'b0));
    send_sample(make_sample(77, 1'b1));
    drain();

    // The channel counter now sits beyond a shrunk channel count: the frame ends at once.
    write_reg(fdem_pkg::CFG_CHANNEL_COUNT, 16'd2);
    cfg_valid <= 1'b0;
    send_sample(make_sample(-5000, 1'b0));
    send_sample(make_sample(5000, 1'b0));
    send_sample(make_sample(-3, 1'b1));
    drain();

    // Shrinking the ring pulls both frame positions back inside it.
    write_reg(fdem_pkg::CFG_RING_FRAMES, 16'd2);
    cfg_valid <= 1'b0;
    ring_now = 2;
    send_sample(make_sample(2097152, 1'b0));
    send_sample(make_sample(-2097152, 1'b1));
    send_sample(make_sample(1, 1'b0));
    drain();
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned burst;
    sent  = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();

    while (sent < RANDOM_ITEMS) begin
      quiet   = (sent + QUIET_ITEMS >= RANDOM_ITEMS);
      idle_on = !quiet && ($urandom_range(0, 3) != 0);
      random_setup(phase == 0);
      burst = $urandom_range(8, 40);
      if (phase == 2) begin
        // Hold the output while samples keep coming, so the block fills and stalls.
        idle_on  = 1'b0;
        hold_req = 1'b1;
        burst    = 40;
      end
      repeat (burst) send_sample(random_sample());
      sent += burst;
      drain();
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("feedback_delay_echo_mixer_core verification clean");
    end else begin
      $display("feedback_delay_echo_mixer_core verification failed");
    end
    $finish;
  end

endmodule
